[src/msc_pkg.sv]
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants, types and the cell edge table of the contour tracer.
// ----------------------------------------------------------------------------
package msc_pkg;

  localparam int PIX_W          = 8;
  localparam int COORD_W        = 20;
  localparam int DIM_W          = 13;
  localparam int ROW_W          = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int MAX_HEIGHT     = 4096;

  localparam logic [PIX_W-1:0] ISO_RST    = 8'd200;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_ISO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_LEFT   = 2'd3;

  typedef struct packed {
    logic [1:0] n;
    logic [1:0] e0;
    logic [1:0] e1;
    logic [1:0] e2;
    logic [1:0] e3;
  } cell_t;

  // Corner bits: TL=8, TR=4, BR=2, BL=1.
  function automatic cell_t cell_lookup(input logic [3:0] code);
    cell_t c;
    c = '{n: 2'd0, e0: SIDE_TOP, e1: SIDE_TOP, e2: SIDE_TOP, e3: SIDE_TOP};
    unique case (code)
      4'd1, 4'd14: c = '{2'd1, SIDE_LEFT, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP};
      4'd2, 4'd13: c = '{2'd1, SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP, SIDE_TOP};
      4'd3, 4'd12: c = '{2'd1, SIDE_LEFT, SIDE_RIGHT, SIDE_TOP, SIDE_TOP};
      4'd4, 4'd11: c = '{2'd1, SIDE_TOP, SIDE_RIGHT, SIDE_TOP, SIDE_TOP};
      4'd5:        c = '{2'd2, SIDE_TOP, SIDE_LEFT, SIDE_BOTTOM, SIDE_RIGHT};
      4'd6, 4'd9:  c = '{2'd1, SIDE_TOP, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP};
      4'd7:        c = '{2'd1, SIDE_TOP, SIDE_LEFT, SIDE_TOP, SIDE_TOP};
      4'd8:        c = '{2'd1, SIDE_LEFT, SIDE_TOP, SIDE_TOP, SIDE_TOP};
      4'd10:       c = '{2'd2, SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT};
      default:     c = '{2'd0, SIDE_TOP, SIDE_TOP, SIDE_TOP, SIDE_TOP};
    endcase
    return c;
  endfunction

endpackage

[src/msc_ram.sv]
// ----------------------------------------------------------------------------
// msc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/msc_div.sv]
// ----------------------------------------------------------------------------
// msc_div
// Restoring divider for the edge weight: (num << FRAC_BITS) / den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msc_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [msc_pkg::PIX_W-1:0]            num,
  input  logic [msc_pkg::PIX_W-1:0]            den,
  output logic                                 done,
  output logic [msc_pkg::PIX_W+FRAC_BITS-1:0]  quot
);
  import msc_pkg::*;

  localparam int QW = PIX_W + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]    dvd_r, dvd_nxt;
  logic [PIX_W:0]   rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [PIX_W:0]   trial;
  logic             qbit;

  assign trial = {rem_r[PIX_W-1:0], dvd_r[QW-1]};
  assign qbit  = (trial >= {1'b0, den});

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {num, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? (trial - {1'b0, den}) : trial;
      dvd_nxt = {dvd_r[QW-2:0], qbit};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

[src/marching_squares_contour_core.sv]
// ----------------------------------------------------------------------------
// marching_squares_contour_core
// Marching-squares contour tracer over a raster pixel stream, with the
// previous row in a line buffer RAM and interpolated segment endpoints.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_       in   tdata[7:0] pixel
// out_      out  tdata: x_start, y_start, x_end, y_end, seg_level; tlast
// cfg_      in   cfg_index register, cfg_data value
//
// A pixel that closes no cell, or a cell with no crossing, goes from S_READ
// back to S_IDLE. A cell with segments runs the weights of all its edges
// in turn through the shared bit-serial divider, then loads each segment
// and holds it through any output stall. The next pixel is taken once the
// last segment has transferred. Reset is synchronous; the line buffer is
// not cleared and reads of never-written columns are undefined.
// ----------------------------------------------------------------------------
module marching_squares_contour_core #(
  parameter int MAX_WIDTH = msc_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [19:0] x_start, [39:20] y_start, [59:40] x_end, [79:60] y_end,
  // [87:80] seg_level
  output logic [87:0]                      out_tdata,
  output logic                             out_tlast,  // last_of_cell
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msc_pkg::DIM_W-1:0]        cfg_data
);
  import msc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = PIX_W + FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [PIX_W-1:0]  iso_r;
  logic [DIM_W-1:0]  img_w_r, img_h_r;
  logic [AW-1:0]     col_r, col_nxt, c_r, c_eff, wm1;
  logic [ROW_W-1:0]  row_r, row_nxt, r_r, hm1;
  logic [PIX_W-1:0]  prev_cur_r, prev_up_r, pix_r;
  logic [PIX_W-1:0]  tl_r, tr_r, bl_r, br_r;
  logic [AW-1:0]     j_r;
  logic [ROW_W-1:0]  i_r;
  cell_t             cell_r, cell_now;
  logic [1:0]        k_r;
  logic              seg_r;
  logic [QW-1:0]     wgt_r [4];
  logic [QW-1:0]     wsel;
  logic [PIX_W-1:0]  v1, v2, num, den;
  logic              div_start, div_done;
  logic [QW-1:0]     div_q;
  logic [PIX_W-1:0]  above;
  logic              ram_re, ram_we;
  logic              in_xfer, out_xfer;
  logic [COORD_W-1:0] xs_r, ys_r, xe_r, ye_r;
  logic [PIX_W-1:0]  lvl_r;
  logic              last_r;
  logic [1:0]        ea, eb;
  logic [COORD_W-1:0] xa, ya, xb, yb;
  logic [3:0]        code;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid && out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r   <= ISO_RST;
      img_w_r <= WIDTH_RST;
      img_h_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ISO:    iso_r   <= cfg_data[PIX_W-1:0];
        REG_WIDTH:  img_w_r <= cfg_data;
        REG_HEIGHT: img_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped frame size, as last index
  always_comb begin
    if (img_w_r < DIM_W'(2)) begin
      wm1 = AW'(1);
    end else if (32'(img_w_r) > 32'(MAX_WIDTH)) begin
      wm1 = AW'(MAX_WIDTH - 1);
    end else begin
      wm1 = AW'(img_w_r - DIM_W'(1));
    end
    if (img_h_r < DIM_W'(2)) begin
      hm1 = ROW_W'(1);
    end else if (32'(img_h_r) > 32'(MAX_HEIGHT)) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(img_h_r - DIM_W'(1));
    end
  end

  assign c_eff = (col_r > wm1) ? wm1 : col_r;

  // Line buffer: read on transfer, write back the new pixel in the following cycle
  assign ram_re = in_xfer;
  assign ram_we = (state_r == S_READ);

  msc_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(c_r),
    .wdata(pix_r),
    .re   (ram_re),
    .raddr(c_eff),
    .rdata(above)
  );

  assign code = {prev_up_r > iso_r, above > iso_r, pix_r > iso_r, prev_cur_r > iso_r};
  assign cell_now = cell_lookup(code);

  // Edge operands: top, right, bottom, left
  always_comb begin
    unique case (k_r)
      SIDE_TOP:    begin v1 = tl_r; v2 = tr_r; end
      SIDE_RIGHT:  begin v1 = tr_r; v2 = br_r; end
      SIDE_BOTTOM: begin v1 = bl_r; v2 = br_r; end
      default:     begin v1 = tl_r; v2 = bl_r; end
    endcase
    num = (iso_r > v1) ? (iso_r - v1) : (v1 - iso_r);
    den = (v2 > v1) ? (v2 - v1) : (v1 - v2);
    if (iso_r == v1) begin
      wsel = '0;
    end else if (iso_r == v2) begin
      wsel = QW'(1) << FRAC_BITS;
    end else if (v1 == v2) begin
      wsel = '0;
    end else begin
      wsel = div_q;
    end
  end

  assign div_start = (state_r == S_DIV);

  msc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (div_q)
  );

  function automatic logic [2*COORD_W-1:0] edge_point(
    input logic [1:0]       e,
    input logic [ROW_W-1:0] i,
    input logic [AW-1:0]    j,
    input logic [QW-1:0]    w0,
    input logic [QW-1:0]    w1,
    input logic [QW-1:0]    w2,
    input logic [QW-1:0]    w3
  );
    logic [47:0] x0, y0, one, px, py;
    x0  = 48'(j) << FRAC_BITS;
    y0  = 48'(i) << FRAC_BITS;
    one = 48'(1) << FRAC_BITS;
    unique case (e)
      SIDE_TOP:    begin px = x0 + 48'(w0); py = y0;             end
      SIDE_RIGHT:  begin px = x0 + one;     py = y0 + 48'(w1);   end
      SIDE_BOTTOM: begin px = x0 + 48'(w2); py = y0 + one;       end
      default:     begin px = x0;           py = y0 + 48'(w3);   end
    endcase
    return {py[COORD_W-1:0], px[COORD_W-1:0]};
  endfunction

  assign ea = seg_r ? cell_r.e2 : cell_r.e0;
  assign eb = seg_r ? cell_r.e3 : cell_r.e1;
  assign {ya, xa} = edge_point(ea, i_r, j_r, wgt_r[0], wgt_r[1], wgt_r[2], wgt_r[3]);
  assign {yb, xb} = edge_point(eb, i_r, j_r, wgt_r[0], wgt_r[1], wgt_r[2], wgt_r[3]);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_READ;
      S_READ: begin
        if (c_r >= wm1) begin
          col_nxt = '0;
          row_nxt = (r_r >= hm1) ? '0 : r_r + ROW_W'(1);
        end else begin
          col_nxt = c_r + AW'(1);
        end
        if (r_r != '0 && c_r != '0 && cell_now.n != 2'd0) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV:  state_nxt = S_WAIT;
      S_WAIT: if (div_done) state_nxt = (k_r == 2'd3) ? S_LOAD : S_DIV;
      S_LOAD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_xfer) begin
          state_nxt = (!seg_r && cell_r.n == 2'd2) ? S_LOAD : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      prev_cur_r <= '0;
      prev_up_r  <= '0;
      k_r        <= '0;
      seg_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (state_r == S_READ) begin
        prev_up_r  <= above;
        prev_cur_r <= pix_r;
        k_r        <= '0;
        seg_r      <= 1'b0;
      end
      if (state_r == S_WAIT && div_done) begin
        k_r <= k_r + 2'd1;
      end
      if (state_r == S_OUT && out_xfer) begin
        seg_r <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r <= in_tdata;
      c_r   <= c_eff;
      r_r   <= row_r;
    end
    if (state_r == S_READ) begin
      tl_r   <= prev_up_r;
      tr_r   <= above;
      bl_r   <= prev_cur_r;
      br_r   <= pix_r;
      cell_r <= cell_now;
      j_r    <= c_r - AW'(1);
      i_r    <= r_r - ROW_W'(1);
    end
    if (state_r == S_WAIT && div_done) begin
      wgt_r[k_r] <= wsel;
    end
    if (state_r == S_LOAD) begin
      xs_r   <= xa;
      ys_r   <= ya;
      xe_r   <= xb;
      ye_r   <= yb;
      lvl_r  <= iso_r;
      last_r <= seg_r || (cell_r.n != 2'd2);
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {lvl_r, ye_r, xe_r, ys_r, xs_r};
  assign out_tlast  = last_r;

  // Checks
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re)) else $error("line buffer read and write collide");

  a_xfer_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_READ) else $error("transfer not followed by read");

  a_second_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && seg_r) |-> cell_r.n == 2'd2)
    else $error("second segment on single-segment cell");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contour tracer core. A predictor inside the
// scoreboard tracks the line buffer and cell position and interpolates the
// expected segments. Directed frames cover saddles, snapping, extremes and
// size clamping. Random frames follow, with bursty stalls on both channels, off for the final ones.
// ----------------------------------------------------------------------------
module tb_top;
  import msc_pkg::*;

  localparam int WDOG_LIMIT = 4000;
  localparam int IDLE_WAIT  = 100;

  typedef struct {
    bit [19:0] xs, ys, xe, ye;
    bit [7:0]  lvl;
    bit        last;
  } seg_t;

  // edges per case, pairs in order start/end
  localparam bit [1:0] SEG_EDGE [16][4] = '{
    '{SIDE_TOP, SIDE_TOP, SIDE_TOP, SIDE_TOP},
    '{SIDE_LEFT, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP},
    '{SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP, SIDE_TOP},
    '{SIDE_LEFT, SIDE_RIGHT, SIDE_TOP, SIDE_TOP},
    '{SIDE_TOP, SIDE_RIGHT, SIDE_TOP, SIDE_TOP},
    '{SIDE_TOP, SIDE_LEFT, SIDE_BOTTOM, SIDE_RIGHT},
    '{SIDE_TOP, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP},
    '{SIDE_TOP, SIDE_LEFT, SIDE_TOP, SIDE_TOP},
    '{SIDE_LEFT, SIDE_TOP, SIDE_TOP, SIDE_TOP},
    '{SIDE_TOP, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP},
    '{SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT},
    '{SIDE_TOP, SIDE_RIGHT, SIDE_TOP, SIDE_TOP},
    '{SIDE_LEFT, SIDE_RIGHT, SIDE_TOP, SIDE_TOP},
    '{SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP, SIDE_TOP},
    '{SIDE_LEFT, SIDE_BOTTOM, SIDE_TOP, SIDE_TOP},
    '{SIDE_TOP, SIDE_TOP, SIDE_TOP, SIDE_TOP}
  };
  localparam int SEG_CNT [16] = '{0, 1, 1, 1, 1, 2, 1, 1, 1, 1, 2, 1, 1, 1, 1, 0};

  class contour_sb;
    bit [7:0]  iso;
    bit [12:0] width, height;
    bit [7:0]  line_buf [MAX_WIDTH_DEF];
    bit [7:0]  left_pix, upleft_pix;
    int        col, row;
    seg_t      seg_q[$];
    int        errors, pixels, segs, saddles;

    function new();
      iso = ISO_RST; width = WIDTH_RST; height = HEIGHT_RST;
      left_pix = 0; upleft_pix = 0; col = 0; row = 0;
      errors = 0; pixels = 0; segs = 0; saddles = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [12:0] val);
      if (idx == REG_ISO) iso = val[7:0];
      else if (idx == REG_WIDTH) width = val;
      else if (idx == REG_HEIGHT) height = val;
    endfunction

    function int eff_width();
      return (width < 2) ? 2 : (width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width);
    endfunction

    function int weight(int v1, int v2);
      int num, den;
      if (iso == v1) return 0;
      if (iso == v2) return 256;
      if (v1 == v2) return 0;
      num = (iso > v1) ? iso - v1 : v1 - iso;
      den = (v2 > v1) ? v2 - v1 : v1 - v2;
      return (num << 8) / den;
    endfunction

    function void edge_pos(bit [1:0] e, int i, int j, int tl, int tr, int bl, int br,
                           output bit [19:0] x, output bit [19:0] y);
      int x0, y0;
      x0 = j << 8;
      y0 = i << 8;
      case (e)
        SIDE_TOP:    begin x = 20'(x0 + weight(tl, tr)); y = 20'(y0); end
        SIDE_RIGHT:  begin x = 20'(x0 + 256); y = 20'(y0 + weight(tr, br)); end
        SIDE_BOTTOM: begin x = 20'(x0 + weight(bl, br)); y = 20'(y0 + 256); end
        default:     begin x = 20'(x0); y = 20'(y0 + weight(tl, bl)); end
      endcase
    endfunction

    function void note_pixel(bit [7:0] pix);
      int w, h, c, r, code, n;
      bit [7:0] above;
      seg_t s;
      w = eff_width();
      h = (height < 2) ? 2 : (height > MAX_HEIGHT) ? MAX_HEIGHT : int'(height);
      c = (col >= w) ? w - 1 : col;
      r = row;
      above = line_buf[c];
      pixels++;
      if (r >= 1 && c >= 1) begin
        code = ((upleft_pix > iso) ? 8 : 0) | ((above > iso) ? 4 : 0) |
               ((pix > iso) ? 2 : 0) | ((left_pix > iso) ? 1 : 0);
        n = SEG_CNT[code];
        if (n == 2) saddles++;
        for (int k = 0; k < n; k++) begin
          edge_pos(SEG_EDGE[code][2*k], r - 1, c - 1, upleft_pix, above, left_pix, pix,
                   s.xs, s.ys);
          edge_pos(SEG_EDGE[code][2*k+1], r - 1, c - 1, upleft_pix, above, left_pix, pix,
                   s.xe, s.ye);
          s.lvl = iso;
          s.last = (k + 1 == n);
          seg_q.push_back(s);
        end
      end
      line_buf[c] = pix;
      upleft_pix = above;
      left_pix = pix;
      if (c >= w - 1) begin
        col = 0;
        row = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_seg(bit [87:0] data, bit last);
      seg_t e;
      if (seg_q.size() == 0) begin
        $display("%0t: unexpected segment %h last %b", $time, data, last);
        errors++;
        return;
      end
      e = seg_q.pop_front();
      segs++;
      if (data[19:0] != e.xs)
        $display("%0t: x_start exp %h got %h", $time, e.xs, data[19:0]);
      if (data[39:20] != e.ys)
        $display("%0t: y_start exp %h got %h", $time, e.ys, data[39:20]);
      if (data[59:40] != e.xe)
        $display("%0t: x_end exp %h got %h", $time, e.xe, data[59:40]);
      if (data[79:60] != e.ye)
        $display("%0t: y_end exp %h got %h", $time, e.ye, data[79:60]);
      if (data[87:80] != e.lvl)
        $display("%0t: seg_level exp %h got %h", $time, e.lvl, data[87:80]);
      if (last != e.last)
        $display("%0t: last_of_cell exp %b got %b", $time, e.last, last);
      if ({data[87:0], last} != {e.lvl, e.ye, e.xe, e.ys, e.xs, e.last}) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  contour_sb sb;
  bit        stalls_on;
  int        quiet_cycles = 0;

  marching_squares_contour_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_seg(out_tdata, out_tlast);
  end

  // receiver stalls in bursts
  int hold_left = 0;
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(1, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // drop the input and hold until every expected segment has transferred
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.seg_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [12:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(bit [7:0] pix);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic bit [7:0] rand_pixel(bit [7:0] lvl);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        v = int'(lvl) + $urandom_range(0, 48) - 24;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end
      6:       return lvl;
      7:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // run to the next frame start so a wider row finds every column written
  task automatic finish_frame();
    while (sb.col != 0 || sb.row != 0) send_pixel(rand_pixel(sb.iso));
  endtask

  initial begin
    bit [7:0] demo [15];
    int n, w;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ISO;
    cfg_data = '0;
    stalls_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: both saddles, corners equal to the level, vertical crossings
    write_reg(REG_ISO, 13'd100);
    write_reg(REG_WIDTH, 13'd3);
    write_reg(REG_HEIGHT, 13'd3);
    demo = '{200, 50, 200, 50, 200, 100, 0, 255, 100, 0, 1, 0, 1, 0, 255};
    for (int k = 0; k < 9; k++) send_pixel(demo[k]);
    // level at both extremes on a 3x2 frame
    write_reg(REG_HEIGHT, 13'd2);
    write_reg(REG_ISO, 13'd0);
    for (int k = 9; k < 15; k++) send_pixel(demo[k]);
    write_reg(REG_ISO, 13'd255);
    for (int k = 9; k < 15; k++) send_pixel(demo[k]);
    write_reg(2'd3, 13'h1555);  // unmapped index, dropped

    // width beyond the buffer (clamped), minimum height (clamped): partial first row
    write_reg(REG_ISO, 13'd128);
    write_reg(REG_WIDTH, 13'h1FFF);
    write_reg(REG_HEIGHT, 13'd0);
    for (int k = 0; k < 150; k++)
      send_pixel(($urandom_range(0, 99) == 0) ? 8'($urandom_range(0, 255)) : 8'd20);

    // narrowest width (clamped), tallest height (clamped), then shrink height
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'h1FFF);
    for (int k = 0; k < 40; k++) send_pixel(rand_pixel(sb.iso));
    write_reg(REG_HEIGHT, 13'd3);

    n = 0;
    while (n < 500) begin
      if (n >= 400) stalls_on = 1'b0;
      write_reg(REG_ISO, ($urandom_range(0, 7) == 0) ?
                ($urandom_range(0, 1) ? 13'd255 : 13'd0) : 13'($urandom_range(0, 255)));
      w = $urandom_range(2, 12);
      if (w > sb.eff_width()) finish_frame();
      write_reg(REG_WIDTH, 13'(w));
      write_reg(REG_HEIGHT, 13'($urandom_range(2, 6)));
      repeat ($urandom_range(10, 60)) begin
        send_pixel(rand_pixel(sb.iso));
        n++;
      end
    end

    in_tvalid <= 1'b0;
    while (sb.seg_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    $display("Pixels sent: %0d, segments checked: %0d, saddle cells: %0d",
             sb.pixels, sb.segs, sb.saddles);
    $display("Covered level extremes, snapped corners, size clamping, random frames to 12x6");
    if (sb.errors == 0 && sb.seg_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
